// ----- rtl/tcc_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// tcc_pkg
// Shared sizes, codes, types and helpers of the triplet to CSC converter.
// ---------------------------------------------------------------------------
package tcc_pkg;

  localparam int MAX_ENTRIES = 4096;
  localparam int MAX_COLS    = 1024;
  localparam int MAX_ROWS    = 1024;

  localparam int ENTRY_AW = $clog2(MAX_ENTRIES);
  localparam int COL_AW   = $clog2(MAX_COLS);
  localparam int START_AW = $clog2(MAX_COLS + 1);
  localparam int NUM_W    = 13;
  localparam int ROW_W    = 10;
  localparam int COLF_W   = 10;
  localparam int VAL_W    = 64;
  localparam int IDX_W    = 13;
  localparam int OP_W     = 3;
  localparam int ST_W     = 3;
  localparam int CFG_W    = 11;
  localparam int CFG_IDX_W = 1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_NUM_ROWS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_NUM_COLS = 1'b1;

  // Input opcodes.
  localparam logic [OP_W-1:0] OP_CLEAR    = 3'd0;
  localparam logic [OP_W-1:0] OP_LOAD     = 3'd1;
  localparam logic [OP_W-1:0] OP_COMPRESS = 3'd2;
  localparam logic [OP_W-1:0] OP_RD_PTR   = 3'd3;
  localparam logic [OP_W-1:0] OP_RD_ENTRY = 3'd4;

  // Result status codes.
  localparam logic [ST_W-1:0] ST_OK          = 3'd0;
  localparam logic [ST_W-1:0] ST_BAD_COLUMN  = 3'd1;
  localparam logic [ST_W-1:0] ST_BAD_ROW     = 3'd2;
  localparam logic [ST_W-1:0] ST_FULL        = 3'd3;
  localparam logic [ST_W-1:0] ST_BAD_INDEX   = 3'd4;
  localparam logic [ST_W-1:0] ST_WRONG_PHASE = 3'd5;

  typedef enum logic [2:0] {
    CMD_CLEAR, CMD_LOAD, CMD_COMPRESS, CMD_RD_PTR, CMD_RD_ENTRY, CMD_BAD
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t           kind;
    logic                col_bad;
    logic                row_bad;
    logic [ROW_W-1:0]    row;
    logic [COLF_W-1:0]   column;
    logic [VAL_W-1:0]    value;
    logic [IDX_W-1:0]    index;
  } cmd_t;

  typedef struct packed {
    logic init_busy;
  } back_stat_t;

  typedef enum logic [1:0] {RES_PLAIN, RES_PTR, RES_ENTRY} res_sel_t;

  typedef enum logic [3:0] {
    S_INIT, S_IDLE, S_CLR, S_LD_RD, S_LD_WR, S_CP_RD, S_CP_ACC,
    S_PL_RD, S_PL_SLOT, S_PL_WR, S_CP_DONE, S_RD, S_FIN
  } state_t;

  function automatic logic [CFG_W-1:0] clamp_dim(input logic [CFG_W-1:0] v,
                                                 input logic [CFG_W-1:0] maxv);
    logic [CFG_W-1:0] r;
    if (v == '0) r = CFG_W'(1);
    else if (v > maxv) r = maxv;
    else r = v;
    return r;
  endfunction

endpackage
`default_nettype wire

// ----- rtl/tcc_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// tcc_in_if / tcc_out_if
// Valid/ready channels for command beats and result beats.
// ---------------------------------------------------------------------------
interface tcc_in_if import tcc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   opcode;
  logic [ROW_W-1:0]  row;
  logic [COLF_W-1:0] column;
  logic [VAL_W-1:0]  value;
  logic [IDX_W-1:0]  index;
  modport source (output valid, opcode, row, column, value, index, input ready);
  modport sink (input valid, opcode, row, column, value, index, output ready);
endinterface

interface tcc_out_if import tcc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [ST_W-1:0]   status;
  logic [NUM_W-1:0]  number;
  logic [ROW_W-1:0]  out_row;
  logic [VAL_W-1:0]  out_value;
  modport source (output valid, status, number, out_row, out_value, input ready);
  modport sink (input valid, status, number, out_row, out_value, output ready);
endinterface
`default_nettype wire

// ----- rtl/tcc_front.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// tcc_front
// Holds the configuration, decodes command beats and queues them for the back.
// ---------------------------------------------------------------------------
module tcc_front import tcc_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_data,
  tcc_in_if.sink                    in_ch,
  input  wire back_stat_t           back_stat,
  input  wire logic                 q_pop,
  output logic                      q_valid,
  output cmd_t                      q_cmd,
  output logic [CFG_W-1:0]          ncols
);

  logic [CFG_W-1:0] num_rows;
  logic [CFG_W-1:0] num_cols;
  logic [CFG_W-1:0] nrows;
  cmd_t             cmd_in;
  cmd_t             q_mem [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       count;
  logic             push;

  always_ff @(posedge clk) begin
    if (rst) begin
      num_rows <= CFG_W'(MAX_ROWS);
      num_cols <= CFG_W'(MAX_COLS);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_NUM_ROWS: num_rows <= cfg_data;
        REG_NUM_COLS: num_cols <= cfg_data;
        default: ;
      endcase
    end
  end

  assign nrows = clamp_dim(num_rows, CFG_W'(MAX_ROWS));
  assign ncols = clamp_dim(num_cols, CFG_W'(MAX_COLS));

  always_comb begin
    case (in_ch.opcode)
      OP_CLEAR:    cmd_in.kind = CMD_CLEAR;
      OP_LOAD:     cmd_in.kind = CMD_LOAD;
      OP_COMPRESS: cmd_in.kind = CMD_COMPRESS;
      OP_RD_PTR:   cmd_in.kind = CMD_RD_PTR;
      OP_RD_ENTRY: cmd_in.kind = CMD_RD_ENTRY;
      default:     cmd_in.kind = CMD_BAD;
    endcase
    cmd_in.col_bad = {1'b0, in_ch.column} >= ncols;
    cmd_in.row_bad = {1'b0, in_ch.row} >= nrows;
    cmd_in.row     = in_ch.row;
    cmd_in.column  = in_ch.column;
    cmd_in.value   = in_ch.value;
    cmd_in.index   = in_ch.index;
  end

  // No beats are taken while the back is clearing the column counts after reset.
  assign in_ch.ready = (count != 2'd2) && !back_stat.init_busy;
  assign push        = in_ch.valid && in_ch.ready;
  assign q_valid     = count != 2'd0;
  assign q_cmd       = q_mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr] <= cmd_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (q_pop) rd_ptr <= !rd_ptr;
      count <= count + 2'(push) - 2'(q_pop);
    end
  end

endmodule
`default_nettype wire

// ----- rtl/tcc_back.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// tcc_back
// Executes queued commands against the triplet store, the column count,
// pointer and slot memories and the compressed store; registers the result.
// ---------------------------------------------------------------------------
module tcc_back import tcc_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             q_valid,
  input  wire cmd_t             q_cmd,
  output logic                  q_pop,
  input  wire logic [CFG_W-1:0] ncols,
  output back_stat_t            back_stat,
  tcc_out_if.source             out_ch
);

  localparam int LD_W = ROW_W + COLF_W + VAL_W;
  localparam int PL_W = ROW_W + VAL_W;

  state_t state, state_next;
  cmd_t   cmd;

  logic [NUM_W-1:0]   entry_count;
  logic               compressed;
  logic [CFG_W-1:0]   latched_cols;
  logic [NUM_W-1:0]   latched_total;
  logic [NUM_W-1:0]   sum;
  logic [CFG_W-1:0]   col_i;
  logic [NUM_W-1:0]   ent_i;
  logic [ST_W-1:0]    res_status;
  logic [NUM_W-1:0]   res_number;
  res_sel_t           res_sel;

  logic               out_valid;
  logic [ST_W-1:0]    out_status;
  logic [NUM_W-1:0]   out_number;
  logic [ROW_W-1:0]   out_row;
  logic [VAL_W-1:0]   out_value;
  logic               out_free;

  // Memories.
  logic [LD_W-1:0]  ld_mem    [MAX_ENTRIES];
  logic [NUM_W-1:0] cnt_mem   [MAX_COLS];
  logic [NUM_W-1:0] start_mem [MAX_COLS+1];
  logic [NUM_W-1:0] slot_mem  [MAX_COLS];
  logic [PL_W-1:0]  pl_mem    [MAX_ENTRIES];

  logic [LD_W-1:0]  ld_q;
  logic [NUM_W-1:0] cnt_q, start_q, slot_q;
  logic [PL_W-1:0]  pl_q;

  logic                ld_we, ld_re;
  logic                cnt_we, cnt_re;
  logic [COL_AW-1:0]   cnt_wa, cnt_ra;
  logic [NUM_W-1:0]    cnt_wd;
  logic                start_we, start_re;
  logic [START_AW-1:0] start_wa, start_ra;
  logic                slot_we, slot_re;
  logic [COL_AW-1:0]   slot_wa, slot_ra;
  logic [NUM_W-1:0]    slot_wd;
  logic                pl_we, pl_re;
  logic [COLF_W-1:0]   ld_col;
  logic                sweep_end;

  assign ld_col    = ld_q[VAL_W +: COLF_W];
  assign sweep_end = col_i == CFG_W'(MAX_COLS - 1);
  assign out_free  = !out_valid || out_ch.ready;
  assign back_stat.init_busy = state == S_INIT;

  always_ff @(posedge clk) begin
    if (ld_we) ld_mem[entry_count[ENTRY_AW-1:0]] <= {cmd.row, cmd.column, cmd.value};
    if (ld_re) ld_q <= ld_mem[ent_i[ENTRY_AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (cnt_we) cnt_mem[cnt_wa] <= cnt_wd;
    if (cnt_re) cnt_q <= cnt_mem[cnt_ra];
  end

  always_ff @(posedge clk) begin
    if (start_we) start_mem[start_wa] <= sum;
    if (start_re) start_q <= start_mem[start_ra];
  end

  always_ff @(posedge clk) begin
    if (slot_we) slot_mem[slot_wa] <= slot_wd;
    if (slot_re) slot_q <= slot_mem[slot_ra];
  end

  always_ff @(posedge clk) begin
    if (pl_we) pl_mem[slot_q[ENTRY_AW-1:0]] <= {ld_q[LD_W-1 -: ROW_W], ld_q[VAL_W-1:0]};
    if (pl_re) pl_q <= pl_mem[cmd.index[ENTRY_AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_INIT;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    q_pop    = 1'b0;
    ld_we    = 1'b0;
    ld_re    = 1'b0;
    cnt_we   = 1'b0;
    cnt_re   = 1'b0;
    cnt_wa   = col_i[COL_AW-1:0];
    cnt_ra   = col_i[COL_AW-1:0];
    cnt_wd   = '0;
    start_we = 1'b0;
    start_re = 1'b0;
    start_wa = col_i[START_AW-1:0];
    start_ra = cmd.index[START_AW-1:0];
    slot_we  = 1'b0;
    slot_re  = 1'b0;
    slot_wa  = col_i[COL_AW-1:0];
    slot_ra  = ld_col;
    slot_wd  = sum;
    pl_we    = 1'b0;
    pl_re    = 1'b0;
    case (state)
      S_INIT, S_CLR: begin
        cnt_we = 1'b1;
        if (sweep_end) state_next = (state == S_INIT) ? S_IDLE : S_FIN;
      end
      S_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          case (q_cmd.kind)
            CMD_CLEAR:    state_next = S_CLR;
            CMD_LOAD: begin
              if (compressed || q_cmd.col_bad || q_cmd.row_bad ||
                  entry_count == NUM_W'(MAX_ENTRIES)) state_next = S_FIN;
              else state_next = S_LD_RD;
            end
            CMD_COMPRESS: state_next = S_CP_RD;
            CMD_RD_PTR: begin
              if (!compressed || q_cmd.index > {2'b0, latched_cols}) state_next = S_FIN;
              else state_next = S_RD;
            end
            CMD_RD_ENTRY: begin
              if (!compressed || q_cmd.index >= latched_total ||
                  q_cmd.index >= NUM_W'(MAX_ENTRIES)) state_next = S_FIN;
              else state_next = S_RD;
            end
            default: state_next = S_FIN;
          endcase
        end
      end
      S_LD_RD: begin
        cnt_re = 1'b1;
        cnt_ra = cmd.column;
        state_next = S_LD_WR;
      end
      S_LD_WR: begin
        cnt_we = 1'b1;
        cnt_wa = cmd.column;
        cnt_wd = cnt_q + NUM_W'(1);
        ld_we  = 1'b1;
        state_next = S_FIN;
      end
      S_CP_RD: begin
        if (col_i == latched_cols) begin
          // Closing pointer of the last column.
          start_we   = 1'b1;
          state_next = S_PL_RD;
        end else begin
          cnt_re     = 1'b1;
          state_next = S_CP_ACC;
        end
      end
      S_CP_ACC: begin
        start_we   = 1'b1;
        slot_we    = 1'b1;
        state_next = S_CP_RD;
      end
      S_PL_RD: begin
        if (ent_i == entry_count) begin
          state_next = S_CP_DONE;
        end else begin
          ld_re      = 1'b1;
          state_next = S_PL_SLOT;
        end
      end
      S_PL_SLOT: begin
        // Triplets whose column fell outside a lowered column count are skipped.
        if ({1'b0, ld_col} < latched_cols) begin
          slot_re    = 1'b1;
          state_next = S_PL_WR;
        end else begin
          state_next = S_PL_RD;
        end
      end
      S_PL_WR: begin
        pl_we   = 1'b1;
        slot_we = 1'b1;
        slot_wa = ld_col;
        slot_wd = slot_q + NUM_W'(1);
        state_next = S_PL_RD;
      end
      S_CP_DONE: state_next = S_FIN;
      S_RD: begin
        start_re   = res_sel == RES_PTR;
        pl_re      = res_sel == RES_ENTRY;
        state_next = S_FIN;
      end
      S_FIN: begin
        if (out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count   <= '0;
      compressed    <= 1'b0;
      latched_cols  <= '0;
      latched_total <= '0;
      col_i         <= '0;
      ent_i         <= '0;
      sum           <= '0;
    end else begin
      case (state)
        S_INIT, S_CLR: begin
          col_i <= col_i + CFG_W'(1);
          if (state == S_CLR && sweep_end) begin
            entry_count <= '0;
            compressed  <= 1'b0;
          end
        end
        S_IDLE: begin
          col_i <= '0;
          ent_i <= '0;
          sum   <= '0;
          if (q_valid) begin
            cmd        <= q_cmd;
            res_status <= ST_OK;
            res_number <= '0;
            res_sel    <= RES_PLAIN;
            case (q_cmd.kind)
              CMD_LOAD: begin
                res_number <= entry_count;
                if (compressed) res_status <= ST_WRONG_PHASE;
                else if (q_cmd.col_bad) res_status <= ST_BAD_COLUMN;
                else if (q_cmd.row_bad) res_status <= ST_BAD_ROW;
                else if (entry_count == NUM_W'(MAX_ENTRIES)) res_status <= ST_FULL;
              end
              CMD_COMPRESS: latched_cols <= ncols;
              CMD_RD_PTR: begin
                if (!compressed) res_status <= ST_WRONG_PHASE;
                else if (q_cmd.index > {2'b0, latched_cols}) res_status <= ST_BAD_INDEX;
                else res_sel <= RES_PTR;
              end
              CMD_RD_ENTRY: begin
                if (!compressed) res_status <= ST_WRONG_PHASE;
                else if (q_cmd.index >= latched_total ||
                         q_cmd.index >= NUM_W'(MAX_ENTRIES)) res_status <= ST_BAD_INDEX;
                else begin
                  res_sel    <= RES_ENTRY;
                  res_number <= latched_total;
                end
              end
              CMD_CLEAR: ;
              default: res_status <= ST_WRONG_PHASE;
            endcase
          end
        end
        S_LD_WR: begin
          entry_count <= entry_count + NUM_W'(1);
          res_number  <= entry_count + NUM_W'(1);
        end
        S_CP_ACC: begin
          sum   <= sum + cnt_q;
          col_i <= col_i + CFG_W'(1);
        end
        S_PL_SLOT: begin
          if ({1'b0, ld_col} >= latched_cols) ent_i <= ent_i + NUM_W'(1);
        end
        S_PL_WR: ent_i <= ent_i + NUM_W'(1);
        S_CP_DONE: begin
          compressed    <= 1'b1;
          latched_total <= sum;
          res_number    <= sum;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_FIN && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_FIN && out_free) begin
      out_status <= res_status;
      out_number <= (res_sel == RES_PTR) ? start_q : res_number;
      out_row    <= (res_sel == RES_ENTRY) ? pl_q[PL_W-1 -: ROW_W] : '0;
      out_value  <= (res_sel == RES_ENTRY) ? pl_q[VAL_W-1:0] : '0;
    end
  end

  assign out_ch.valid     = out_valid;
  assign out_ch.status    = out_status;
  assign out_ch.number    = out_number;
  assign out_ch.out_row   = out_row;
  assign out_ch.out_value = out_value;

endmodule
`default_nettype wire

// ----- rtl/triplet_to_csc_compress_top.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// triplet_to_csc_compress_top
// Triplet to compressed sparse column converter by counting sort.
// ---------------------------------------------------------------------------
// Commands arrive as beats on in_ch (clear, load, compress, read pointer,
// read entry); each gives exactly one result beat on out_ch. num_rows and
// num_cols are written on the cfg port while the block is idle.
// A two-deep command queue sits in front of a sequential executor, so the
// sender can post up to two beats while a command is still running.
// Each command runs as a series of steps of the executor: compress first
// sums the column counts into column pointers, then places every stored
// triplet into its column's next slot, skipping a triplet whose column lies
// outside the column count.
// After reset the column counts are swept to zero, during which in_ch.ready
// stays low. A stalled result is held in the output register; the executor
// then waits, and the queue fills and backs up in_ch.
// ---------------------------------------------------------------------------
module triplet_to_csc_compress_top import tcc_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_data,
  tcc_in_if.sink                    in_ch,
  tcc_out_if.source                 out_ch
);

  back_stat_t       back_stat;
  logic             q_pop;
  logic             q_valid;
  cmd_t             q_cmd;
  logic [CFG_W-1:0] ncols;

  tcc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_ch     (in_ch),
    .back_stat (back_stat),
    .q_pop     (q_pop),
    .q_valid   (q_valid),
    .q_cmd     (q_cmd),
    .ncols     (ncols)
  );

  tcc_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_cmd     (q_cmd),
    .q_pop     (q_pop),
    .ncols     (ncols),
    .back_stat (back_stat),
    .out_ch    (out_ch)
  );

endmodule
`default_nettype wire

// ----- rtl/tcc_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// tcc_checker
// Port-level checks of the converter, bound to the top level.
// ---------------------------------------------------------------------------
module tcc_checker import tcc_pkg::*; (
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              in_ready,
  input wire logic              out_valid,
  input wire logic              out_ready,
  input wire logic [ST_W-1:0]   out_status,
  input wire logic [NUM_W-1:0]  out_number,
  input wire logic [ROW_W-1:0]  out_row,
  input wire logic [VAL_W-1:0]  out_value
);

  // A held result beat keeps its status and number.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_status) && $stable(out_number))
    else $error("result beat changed while stalled");

  // Only a successful entry read carries row and value.
  a_entry_only: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_status != ST_OK |-> out_row == '0 && out_value == '0)
    else $error("refused command returned entry data");

  // A refused read returns no number.
  a_bad_index: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_status == ST_BAD_INDEX |-> out_number == '0)
    else $error("bad index result has nonzero number");

  // The count clearing sweep follows reset, so no beat is taken right after it.
  a_init: assert property (@(posedge clk)
    !rst && $past(rst) |-> !in_ready && !out_valid)
    else $error("block ready right after reset");

endmodule

bind triplet_to_csc_compress_top tcc_checker u_checker (
  .clk        (clk),
  .rst        (rst),
  .in_ready   (in_ch.ready),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .out_status (out_ch.status),
  .out_number (out_ch.number),
  .out_row    (out_ch.out_row),
  .out_value  (out_ch.out_value)
);
`default_nettype wire
